// ----- sv/achia_pkg.sv -----
// shared types and constants for the ambient color hue and intensity adjust unit
`default_nettype none

package achia_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int CHANNEL_W         = 8;
    localparam int SUM_W             = 10;
    localparam int CFG_W             = 17;
    localparam int CFG_INDEX_W       = 2;
    localparam int RECIP_DEPTH       = 256;
    localparam int INTENSITY_DIV     = 765;
    localparam int VALID_STAGES      = 6;

    localparam logic [CFG_W-1:0] HUE_STRENGTH_RESET       = 17'd65536;
    localparam logic [CFG_W-1:0] INTENSITY_STRENGTH_RESET = 17'd42598;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HUE_STRENGTH       = 2'd0,
        CFG_INTENSITY_STRENGTH = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [CHANNEL_W-1:0] red_in;
        logic [CHANNEL_W-1:0] green_in;
        logic [CHANNEL_W-1:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [CHANNEL_W-1:0] red_out;
        logic [CHANNEL_W-1:0] green_out;
        logic [CHANNEL_W-1:0] blue_out;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/achia_blend.sv -----
// registered blend of a fixed point value toward white with clamp to [0,1]
`default_nettype none

module achia_blend #(
    parameter int FRAC_BITS = achia_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic [FRAC_BITS:0]    v,
    input  wire logic signed [FRAC_BITS+1:0] k,
    output logic      [FRAC_BITS:0]    vw
);

    localparam int TW = 2 * FRAC_BITS + 4;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [TW-1:0] ONE_SQ = {{(TW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);

    logic [FRAC_BITS:0]    comp;
    logic signed [TW-1:0]  kprod;
    logic signed [TW-1:0]  vsh;
    logic signed [TW-1:0]  t;
    logic [FRAC_BITS:0]    vw_next;
    logic [FRAC_BITS:0]    vw_reg;

    always_comb
    begin
        comp  = ONE - v;
        kprod = k * $signed({1'b0, comp});
        vsh   = $signed({3'b000, v, {FRAC_BITS{1'b0}}});
        t     = vsh + kprod;
        if (t[TW-1])
        begin
            vw_next = '0;
        end
        else if (t > ONE_SQ)
        begin
            vw_next = ONE;
        end
        else
        begin
            vw_next = t[2*FRAC_BITS:FRAC_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        vw_reg <= vw_next;
    end

    assign vw = vw_reg;

endmodule

`default_nettype wire

// ----- sv/achia_lane.sv -----
// one color channel lane: hue divide, blend toward white, scale by intensity
`default_nettype none

module achia_lane #(
    parameter int FRAC_BITS = achia_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic [achia_pkg::CHANNEL_W-1:0]     channel,
    input  wire logic [achia_pkg::CHANNEL_W-1:0]     max_ch,
    input  wire logic [FRAC_BITS+8:0]                recip,
    input  wire logic signed [FRAC_BITS+1:0]         kh,
    input  wire logic [FRAC_BITS:0]                  fiw,
    output logic      [achia_pkg::CHANNEL_W-1:0]     scaled
);

    localparam int CW = achia_pkg::CHANNEL_W;
    localparam int RW = FRAC_BITS + 9;
    localparam int PW = 2 * FRAC_BITS + 2;

    logic [CW+RW-1:0]      qe_full;
    logic [FRAC_BITS:0]    qe_next;
    logic [FRAC_BITS:0]    qe_reg;
    logic [CW-1:0]         c_reg;
    logic [CW-1:0]         mx_reg;
    logic [FRAC_BITS+8:0]  chk;
    logic [FRAC_BITS+8:0]  xsh;
    logic [FRAC_BITS+8:0]  rem;
    logic [FRAC_BITS:0]    hue_next;
    logic [FRAC_BITS:0]    hue_reg;
    logic [FRAC_BITS:0]    hw;
    logic [PW-1:0]         prod_next;
    logic [PW-1:0]         prod_reg;
    logic [PW+7:0]         prod255;

    // quotient estimate from the reciprocal, at most one below the true value
    always_comb
    begin
        qe_full = channel * recip;
        qe_next = qe_full[FRAC_BITS+8:8];
    end

    always_comb
    begin
        chk = qe_reg * mx_reg;
        xsh = {1'b0, c_reg, {FRAC_BITS{1'b0}}};
        rem = xsh - chk;
        // black pixel has no maximum, hue stays zero
        if ((mx_reg != '0) && (rem >= {{(FRAC_BITS+1){1'b0}}, mx_reg}))
        begin
            hue_next = qe_reg + 1'b1;
        end
        else
        begin
            hue_next = qe_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        qe_reg   <= qe_next;
        c_reg    <= channel;
        mx_reg   <= max_ch;
        hue_reg  <= hue_next;
        prod_reg <= prod_next;
    end

    achia_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .clk (clk),
        .v   (hue_reg),
        .k   (kh),
        .vw  (hw)
    );

    always_comb
    begin
        prod_next = hw * fiw;
        prod255   = {prod_reg, 8'b0} - {8'b0, prod_reg};
        scaled    = prod255[2*FRAC_BITS+7:2*FRAC_BITS];
    end

endmodule

`default_nettype wire

// ----- sv/ambient_color_hue_intensity_adjust_unit.sv -----
// top level of the ambient color hue and intensity adjust unit
// Takes one RGB pixel per clock with no stall on either side: busy stays low and
// cfg_ready stays high. Each accepted pixel transaction yields one result through
// the lane pipeline registers: input register, reciprocal multiply, quotient
// correction, blend toward white, intensity product and merge register.
// done marks the result for one cycle and the receiver has to take it then.
// Write the strength registers only while no pixel is in flight.
`default_nettype none

module ambient_color_hue_intensity_adjust_unit #(
    parameter int FRAC_BITS = achia_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire achia_pkg::pixel_t                  pixel,
    output logic                                    done,
    output achia_pkg::result_t                      result,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire achia_pkg::cfg_index_t              cfg_index,
    input  wire logic [achia_pkg::CFG_W-1:0]        cfg_data
);

    localparam int CW  = achia_pkg::CHANNEL_W;
    localparam int SW  = achia_pkg::SUM_W;
    localparam int RW  = FRAC_BITS + 9;
    localparam int VS  = achia_pkg::VALID_STAGES;
    localparam int FW  = FRAC_BITS + SW + 1;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS:0] RECIP_765 =
        (FRAC_BITS+1)'((64'd1 << (FRAC_BITS + SW)) / achia_pkg::INTENSITY_DIV);

    logic [achia_pkg::CFG_W-1:0]  hue_strength_reg;
    logic [achia_pkg::CFG_W-1:0]  intensity_strength_reg;
    logic [achia_pkg::CFG_W+FRAC_BITS-1:0] hs_wide;
    logic [achia_pkg::CFG_W+FRAC_BITS-1:0] is_wide;
    logic signed [FRAC_BITS+1:0]  kh;
    logic signed [FRAC_BITS+1:0]  ki;

    logic [VS-1:0]                vld_reg;
    achia_pkg::pixel_t            pixel_reg;
    achia_pkg::result_t           result_reg;
    achia_pkg::result_t           result_next;

    logic [CW-1:0]                mx;
    logic [SW-1:0]                sum;
    logic [RW-1:0]                recip;
    logic [RW-1:0]                recip_tab [achia_pkg::RECIP_DEPTH];
    logic [FW-1:0]                fprod;
    logic [FRAC_BITS:0]           fie_next;
    logic [FRAC_BITS:0]           fie_reg;
    logic [SW-1:0]                sum_reg;
    logic [FW-1:0]                fchk;
    logic [FW-1:0]                fxs;
    logic [FW-1:0]                frem;
    logic [FRAC_BITS:0]           fi_next;
    logic [FRAC_BITS:0]           fi_reg;
    logic [FRAC_BITS:0]           fiw;
    logic [CW-1:0]                red_scaled;
    logic [CW-1:0]                green_scaled;
    logic [CW-1:0]                blue_scaled;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = vld_reg[VS-1];
    assign result    = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_strength_reg       <= achia_pkg::HUE_STRENGTH_RESET;
            intensity_strength_reg <= achia_pkg::INTENSITY_STRENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                achia_pkg::CFG_HUE_STRENGTH:       hue_strength_reg       <= cfg_data;
                achia_pkg::CFG_INTENSITY_STRENGTH: intensity_strength_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // strength in Q16 rescaled to FRAC_BITS, factor is one minus strength
    always_comb
    begin
        hs_wide = {hue_strength_reg, {FRAC_BITS{1'b0}}};
        is_wide = {intensity_strength_reg, {FRAC_BITS{1'b0}}};
        kh = $signed({1'b0, ONE}) - $signed({1'b0, hs_wide[FRAC_BITS+16:16]});
        ki = $signed({1'b0, ONE}) - $signed({1'b0, is_wide[FRAC_BITS+16:16]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[VS-2:0], start && !busy};
        end
    end

    // reciprocal table, floor(2^(FRAC_BITS+8) / m)
    for (genvar gi = 0; gi < achia_pkg::RECIP_DEPTH; gi++)
    begin : g_recip
        localparam int unsigned Den = (gi == 0) ? 1 : gi;
        localparam logic [RW-1:0] RecipVal =
            (gi == 0) ? '0 : RW'((64'd1 << (FRAC_BITS + 8)) / Den);
        assign recip_tab[gi] = RecipVal;
    end

    always_comb
    begin
        mx = pixel_reg.red_in;
        if (pixel_reg.green_in > mx)
        begin
            mx = pixel_reg.green_in;
        end
        if (pixel_reg.blue_in > mx)
        begin
            mx = pixel_reg.blue_in;
        end
        sum = {2'b00, pixel_reg.red_in} + {2'b00, pixel_reg.green_in}
            + {2'b00, pixel_reg.blue_in};
        recip    = recip_tab[mx];
        fprod    = sum * RECIP_765;
        fie_next = fprod[FRAC_BITS+SW:SW];
    end

    // intensity quotient correction by one compare and subtract
    always_comb
    begin
        fchk = fie_reg * SW'(achia_pkg::INTENSITY_DIV);
        fxs  = {1'b0, sum_reg, {FRAC_BITS{1'b0}}};
        frem = fxs - fchk;
        if (frem >= FW'(achia_pkg::INTENSITY_DIV))
        begin
            fi_next = fie_reg + 1'b1;
        end
        else
        begin
            fi_next = fie_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg  <= pixel;
        fie_reg    <= fie_next;
        sum_reg    <= sum;
        fi_reg     <= fi_next;
        result_reg <= result_next;
    end

    achia_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_int_blend (
        .clk (clk),
        .v   (fi_reg),
        .k   (ki),
        .vw  (fiw)
    );

    achia_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_red (
        .clk     (clk),
        .channel (pixel_reg.red_in),
        .max_ch  (mx),
        .recip   (recip),
        .kh      (kh),
        .fiw     (fiw),
        .scaled  (red_scaled)
    );

    achia_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_green (
        .clk     (clk),
        .channel (pixel_reg.green_in),
        .max_ch  (mx),
        .recip   (recip),
        .kh      (kh),
        .fiw     (fiw),
        .scaled  (green_scaled)
    );

    achia_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_blue (
        .clk     (clk),
        .channel (pixel_reg.blue_in),
        .max_ch  (mx),
        .recip   (recip),
        .kh      (kh),
        .fiw     (fiw),
        .scaled  (blue_scaled)
    );

    // merge the lanes into one result transaction
    always_comb
    begin
        result_next.red_out   = red_scaled;
        result_next.green_out = green_scaled;
        result_next.blue_out  = blue_scaled;
    end

endmodule

`default_nettype wire

// ----- sv/achia_checker.sv -----
// port level checks for the ambient color hue and intensity adjust unit
`default_nettype none

module achia_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire achia_pkg::pixel_t     pixel,
    input wire logic                  done,
    input wire achia_pkg::result_t    result,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready
);

    // every accepted pixel comes out after a fixed latency
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##6 done)
        else $error("accepted pixel produced no result");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 6))
        else $error("result with no matching pixel");

    // channel order survives the adjustment
    a_order_rg: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(pixel.red_in >= pixel.green_in, 6))
        |-> (result.red_out >= result.green_out))
        else $error("red and green order flipped");

    a_order_gb: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(pixel.green_in >= pixel.blue_in, 6))
        |-> (result.green_out >= result.blue_out))
        else $error("green and blue order flipped");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write held off");

endmodule

bind ambient_color_hue_intensity_adjust_unit achia_checker u_checker (.*);

`default_nettype wire

// ----- verif/ambient_color_hue_intensity_adjust_unit_tb.sv -----
// self-checking testbench for the ambient color hue and intensity adjust unit
`default_nettype none

module ambient_color_hue_intensity_adjust_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import achia_pkg::*;

    localparam int FRAC = FRAC_BITS_DEFAULT;
    localparam longint ONE = longint'(1) << FRAC;
    localparam int STRENGTH_UNITY = 65536;
    localparam int STRENGTH_MAX = (1 << CFG_W) - 1;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_PIXELS = 190;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE = 2'd2;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    pixel_t pixel = '0;
    logic done;
    result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    cfg_index_t cfg_index = CFG_HUE_STRENGTH;
    logic [CFG_W-1:0] cfg_data = '0;

    pixel_t pending_pixels[$];
    result_t expected_colors[$];
    logic [CFG_W-1:0] hue_shadow = HUE_STRENGTH_RESET;
    logic [CFG_W-1:0] intensity_shadow = INTENSITY_STRENGTH_RESET;
    int idle_pct = 0;
    int idle_left = 0;
    int quiet_cycles = 0;
    int error_count = 0;
    result_t want_color;

    ambient_color_hue_intensity_adjust_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .pixel(pixel),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // pull v toward full scale by k, clamp to [0, ONE]
    function automatic longint blend_toward_white(longint v, longint k);
        longint t;
        t = v * ONE + k * (ONE - v);
        if (t < 0)
            t = 0;
        if (t > ONE * ONE)
            t = ONE * ONE;
        return t / ONE;
    endfunction

    function automatic result_t predict_adjusted(pixel_t px, logic [CFG_W-1:0] hue_reg,
                                                 logic [CFG_W-1:0] int_reg);
        longint chan[3];
        longint peak;
        longint total;
        longint k_hue;
        longint k_int;
        longint level;
        longint hue;
        logic [CHANNEL_W-1:0] adj[3];
        chan[0] = px.red_in;
        chan[1] = px.green_in;
        chan[2] = px.blue_in;
        peak = 0;
        total = 0;
        for (int i = 0; i < 3; i++)
        begin
            total += chan[i];
            if (chan[i] > peak)
                peak = chan[i];
        end
        k_hue = ONE - (longint'(hue_reg) * ONE) / STRENGTH_UNITY;
        k_int = ONE - (longint'(int_reg) * ONE) / STRENGTH_UNITY;
        level = blend_toward_white((total * ONE) / INTENSITY_DIV, k_int);
        for (int i = 0; i < 3; i++)
        begin
            hue = (peak == 0) ? 0 : (chan[i] * ONE) / peak;
            hue = blend_toward_white(hue, k_hue);
            adj[i] = CHANNEL_W'((hue * level * 255) / (ONE * ONE));
        end
        return '{red_out: adj[0], green_out: adj[1], blue_out: adj[2]};
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t px;
        px = pixel_t'($urandom);
        case ($urandom_range(0, 9))
            0: px = ($urandom_range(0, 1) != 0) ? '0 : '1;
            1: px.green_in = '0;
            2:
            begin
                px.green_in = px.red_in;
                px.blue_in = px.red_in;
            end
            3: px.blue_in = '1;
            4: px.red_in = CHANNEL_W'($urandom_range(0, 3));
            default: ;
        endcase
        return px;
    endfunction

    function automatic logic [CFG_W-1:0] random_strength();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return CFG_W'(STRENGTH_UNITY);
            2: return CFG_W'(STRENGTH_MAX);
            3: return CFG_W'($urandom_range(STRENGTH_UNITY + 1, STRENGTH_MAX));
            default: return CFG_W'($urandom_range(0, STRENGTH_UNITY));
        endcase
    endfunction

    task automatic push_pixel(int r, int g, int b);
        pending_pixels.push_back('{red_in: r[7:0], green_in: g[7:0], blue_in: b[7:0]});
    endtask

    task automatic write_strength(cfg_index_t idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // hold off until every transaction has come back and the pipeline has emptied
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_pixels.size() != 0 || start || expected_colors.size() != 0);
        repeat (VALID_STAGES + 2) @(negedge clk);
    endtask

    task automatic check_channel(string name, logic [CHANNEL_W-1:0] want,
                                 logic [CHANNEL_W-1:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // driver: feeds pixels and predicts each accepted transaction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            idle_left = 0;
            hue_shadow = HUE_STRENGTH_RESET;
            intensity_shadow = INTENSITY_STRENGTH_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HUE_STRENGTH: hue_shadow = cfg_data;
                    CFG_INTENSITY_STRENGTH: intensity_shadow = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_colors.push_back(predict_adjusted(pixel, hue_shadow, intensity_shadow));
            if (start && busy)
                ;
            else if (idle_left > 0)
            begin
                start <= 1'b0;
                idle_left--;
            end
            else if (pending_pixels.size() != 0 && idle_pct != 0
                     && $urandom_range(0, 99) < idle_pct)
            begin
                start <= 1'b0;
                idle_left = $urandom_range(0, 4);
            end
            else if (pending_pixels.size() != 0)
            begin
                start <= 1'b1;
                pixel <= pending_pixels.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_colors.size() == 0)
                begin
                    error_count++;
                    $display("%0t unexpected result: expected none actual %h", $time, result);
                end
                else
                begin
                    want_color = expected_colors.pop_front();
                    check_channel("red_out", want_color.red_out, result.red_out);
                    check_channel("green_out", want_color.green_out, result.green_out);
                    check_channel("blue_out", want_color.blue_out, result.blue_out);
                end
            end
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset strengths: corners of the color cube and a few mixed colors
        idle_pct = 20;
        @(negedge clk);
        push_pixel(0, 0, 0);
        push_pixel(255, 255, 255);
        push_pixel(255, 0, 0);
        push_pixel(0, 255, 0);
        push_pixel(0, 0, 255);
        push_pixel(1, 0, 0);
        push_pixel(0, 0, 1);
        push_pixel(1, 1, 1);
        push_pixel(170, 85, 170);
        push_pixel(85, 170, 85);
        push_pixel(128, 64, 32);
        push_pixel(254, 255, 253);
        wait_drained();

        // zero strength pushes everything to white
        write_strength(CFG_HUE_STRENGTH, '0);
        write_strength(CFG_INTENSITY_STRENGTH, '0);
        @(negedge clk);
        push_pixel(0, 0, 0);
        push_pixel(255, 255, 255);
        push_pixel(255, 0, 0);
        push_pixel(7, 128, 250);
        wait_drained();

        // strength above unity, blend clamps at zero
        write_strength(CFG_HUE_STRENGTH, CFG_W'(STRENGTH_MAX));
        write_strength(CFG_INTENSITY_STRENGTH, CFG_W'(STRENGTH_MAX));
        @(negedge clk);
        push_pixel(0, 0, 0);
        push_pixel(255, 255, 255);
        push_pixel(0, 255, 0);
        push_pixel(200, 100, 1);
        wait_drained();

        // spare index must not touch either strength
        write_strength(CFG_HUE_STRENGTH, CFG_W'(STRENGTH_UNITY));
        write_strength(CFG_INTENSITY_STRENGTH, CFG_W'(STRENGTH_UNITY));
        write_strength(cfg_index_t'(CFG_INDEX_SPARE), '0);
        @(negedge clk);
        push_pixel(0, 0, 0);
        push_pixel(255, 255, 255);
        push_pixel(0, 0, 255);
        push_pixel(33, 66, 99);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if ($urandom_range(0, 1) != 0)
            begin
                write_strength(CFG_HUE_STRENGTH, random_strength());
                write_strength(CFG_INTENSITY_STRENGTH, random_strength());
            end
            else
            begin
                write_strength(CFG_INTENSITY_STRENGTH, random_strength());
                write_strength(CFG_HUE_STRENGTH, random_strength());
            end
            if ($urandom_range(0, 3) == 0)
                write_strength(cfg_index_t'(CFG_INDEX_SPARE), CFG_W'($urandom));
            @(negedge clk);
            if (phase == RANDOM_PHASES - 1)
                idle_pct = 0;
            else
                idle_pct = (phase % 3 == 1) ? 0 : $urandom_range(10, 40);
            for (int n = 0; n < PHASE_PIXELS; n++)
                pending_pixels.push_back(random_pixel());
            wait_drained();
        end

        if (expected_colors.size() != 0)
        begin
            error_count++;
            $display("%0t results missing: expected %0d actual 0", $time,
                     expected_colors.size());
        end
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
sv/achia_pkg.sv
sv/achia_blend.sv
sv/achia_lane.sv
sv/ambient_color_hue_intensity_adjust_unit.sv
sv/achia_checker.sv
verif/ambient_color_hue_intensity_adjust_unit_tb.sv
